/* rtl/nsr_pkg.sv */
// Package for the Newton square root block.
// Holds the fixed-point widths, the step limit, the result type and the start-value tables.
// Used by every module in rtl/ and by the checker.
package nsr_pkg;

	localparam int FRAC_BITS = 32;
	localparam int MAX_STEPS = 63;
	localparam int N_W       = 31;
	localparam int T_W       = N_W + 2 * FRAC_BITS;
	localparam int G_W       = T_W + 1;
	localparam int A_W       = G_W + 1;
	localparam int GI_W      = 16 + FRAC_BITS;
	localparam int ROOT_W    = 48;
	localparam int STEP_W    = 6;
	localparam int TOL_W     = 32;
	localparam int CNT_W     = $clog2(T_W);
	localparam int G0_W      = 16;

	typedef struct packed {
		logic [ROOT_W-1:0] root;
		logic [STEP_W-1:0] iterations;
		logic              hit_limit;
	} nsr_res_t;

	typedef struct packed {
		logic idle;
		logic done;
	} nsr_stat_t;

	// Thresholds for the decimal digit-pair start value, indexed by pair count.
	function automatic logic [N_W-1:0] pair_limit(input logic [2:0] p);
		case (p)
			3'd1:    pair_limit = N_W'(100);
			3'd2:    pair_limit = N_W'(10000);
			3'd3:    pair_limit = N_W'(1000000);
			3'd4:    pair_limit = N_W'(100000000);
			default: pair_limit = '0;
		endcase
	endfunction

	function automatic logic [N_W-1:0] ten_limit(input logic [2:0] p);
		case (p)
			3'd0:    ten_limit = N_W'(10);
			3'd1:    ten_limit = N_W'(1000);
			3'd2:    ten_limit = N_W'(100000);
			3'd3:    ten_limit = N_W'(10000000);
			default: ten_limit = N_W'(1000000000);
		endcase
	endfunction

	function automatic logic [G0_W-1:0] pow10(input logic [2:0] p);
		case (p)
			3'd0:    pow10 = G0_W'(1);
			3'd1:    pow10 = G0_W'(10);
			3'd2:    pow10 = G0_W'(100);
			3'd3:    pow10 = G0_W'(1000);
			default: pow10 = G0_W'(10000);
		endcase
	endfunction

endpackage

/* rtl/nsr_start.sv */
// Start-value selection for the Newton square root block, by threshold compares.
// Counts decimal digit pairs; g0 is 2 or 6 x 10^pairs, or 1 in guess mode or for zero.
// Depends on nsr_pkg.
module nsr_start import nsr_pkg::*; (
	input  logic [N_W-1:0]  radicand,
	input  logic            guess_mode,
	output logic [G0_W-1:0] g0
);

	logic [2:0] pairs;

	always_comb begin
		pairs = 3'd0;
		for (int k = 1; k <= 4; k++) begin
			if (radicand >= pair_limit(3'(k))) begin
				pairs = 3'(k);
			end
		end
		if (guess_mode || radicand == '0) begin
			g0 = G0_W'(1);
		end else if (radicand < ten_limit(pairs)) begin
			g0 = G0_W'(pow10(pairs) << 1);
		end else begin
			g0 = G0_W'((pow10(pairs) << 2) + (pow10(pairs) << 1));
		end
	end

endmodule

/* rtl/nsr_core.sv */
// Sequencer and shared add/subtract datapath of the Newton square root block.
// Squares by shift-add, divides by restoring division, all through one adder.
// Depends on nsr_pkg.
module nsr_core import nsr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [N_W-1:0]   radicand,
	input  logic [G0_W-1:0]  g0,
	input  logic [TOL_W-1:0] tolerance,
	input  logic             out_free,
	output nsr_stat_t        stat,
	output nsr_res_t         res
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_TEST = 4'd1;
	localparam logic [3:0] S_MUL  = 4'd2;
	localparam logic [3:0] S_DIFF = 4'd3;
	localparam logic [3:0] S_ABS  = 4'd4;
	localparam logic [3:0] S_TOL  = 4'd5;
	localparam logic [3:0] S_LIM  = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_ADD  = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0]        state_q;
	logic [G_W-1:0]    g_q;
	logic [A_W-1:0]    acc_q;
	logic [T_W-1:0]    qn_q;
	logic [N_W-1:0]    n_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [STEP_W-1:0] steps_q;
	logic              hit_q;
	logic              neg_q;

	logic [A_W-1:0] opa;
	logic [A_W-1:0] opb;
	logic           sub;
	logic [A_W:0]   sum;
	logic [A_W-1:0] add_res;
	logic           borrow;
	logic [T_W-1:0] target;
	logic [A_W-1:0] tol_ext;
	logic           qbit;

	assign target  = {n_q, {(2 * FRAC_BITS){1'b0}}};
	assign tol_ext = A_W'({tolerance, {FRAC_BITS{1'b0}}});

	always_comb begin
		opa = '0;
		opb = '0;
		sub = 1'b0;
		case (state_q)
			S_MUL: begin
				opa = {acc_q[A_W-2:0], 1'b0};
				opb = g_q[cnt_q] ? A_W'(g_q[GI_W-1:0]) : '0;
			end
			S_DIFF: begin
				opa = acc_q;
				opb = A_W'(target);
				sub = 1'b1;
			end
			S_ABS: begin
				opb = acc_q;
				sub = 1'b1;
			end
			S_TOL: begin
				opa = acc_q;
				opb = tol_ext;
				sub = 1'b1;
			end
			S_DIV: begin
				opa = {acc_q[A_W-2:0], qn_q[T_W-1]};
				opb = A_W'(g_q);
				sub = 1'b1;
			end
			S_ADD: begin
				opa = A_W'(g_q);
				opb = A_W'(qn_q);
			end
			default: begin
				opa = '0;
			end
		endcase
		sum     = {1'b0, opa} + {1'b0, opb ^ {A_W{sub}}} + (A_W + 1)'(sub);
		add_res = sum[A_W-1:0];
		borrow  = sub & ~sum[A_W];
		qbit    = ~borrow & (g_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (start) state_q <= S_TEST;
				S_TEST: state_q <= (g_q[G_W-1:GI_W] != '0) ? S_LIM : S_MUL;
				S_MUL:  if (cnt_q == '0) state_q <= S_DIFF;
				S_DIFF: state_q <= S_ABS;
				S_ABS:  state_q <= S_TOL;
				S_TOL:  state_q <= borrow ? S_DONE : S_LIM;
				S_LIM:  state_q <= (steps_q == STEP_W'(MAX_STEPS)) ? S_DONE : S_DIV;
				S_DIV:  if (cnt_q == '0) state_q <= S_ADD;
				S_ADD:  state_q <= S_TEST;
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					n_q     <= radicand;
					g_q     <= {{(G_W - G0_W - FRAC_BITS){1'b0}}, g0, {FRAC_BITS{1'b0}}};
					steps_q <= '0;
					hit_q   <= 1'b0;
				end
			end
			S_TEST: begin
				acc_q <= '0;
				cnt_q <= CNT_W'(GI_W - 1);
			end
			S_MUL: begin
				acc_q <= add_res;
				cnt_q <= cnt_q - 1'b1;
			end
			S_DIFF: begin
				acc_q <= add_res;
				neg_q <= borrow;
			end
			S_ABS: begin
				if (neg_q) acc_q <= add_res;
			end
			S_LIM: begin
				if (steps_q == STEP_W'(MAX_STEPS)) hit_q <= 1'b1;
				acc_q <= '0;
				qn_q  <= target;
				cnt_q <= CNT_W'(T_W - 1);
			end
			S_DIV: begin
				acc_q <= qbit ? add_res : {acc_q[A_W-2:0], qn_q[T_W-1]};
				qn_q  <= {qn_q[T_W-2:0], qbit};
				cnt_q <= cnt_q - 1'b1;
			end
			S_ADD: begin
				g_q     <= add_res[A_W-1:1];
				steps_q <= steps_q + 1'b1;
			end
			default: begin
				neg_q <= neg_q;
			end
		endcase
	end

	assign stat.idle      = (state_q == S_IDLE);
	assign stat.done      = (state_q == S_DONE) && out_free;
	assign res.root       = g_q[ROOT_W-1:0];
	assign res.iterations = steps_q;
	assign res.hit_limit  = hit_q;

endmodule

/* rtl/newton_square_root.sv */
// Top level of the Newton square root block: configuration registers, handshakes, result register.
// Instantiates nsr_start and nsr_core; depends on nsr_pkg.
//
// Channel  | Handshake            | Payload
// in       | in_valid / in_ready  | radicand
// out      | out_valid / out_ready| root, iterations, hit_limit
// cfg      | cfg_we               | cfg_index, cfg_data
//
// Each Newton step runs the shift-add square, the restoring division, and the compare
// and update states, all on one shared adder.
// The block takes a new beat only when its sequencer is idle; a result waiting on out_ready
// does not block the next beat, but the sequencer holds its finished result until the
// output register is free. Reset clears control state and loads the register defaults.
module newton_square_root import nsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [N_W-1:0]    radicand,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ROOT_W-1:0] root,
	output logic [STEP_W-1:0] iterations,
	output logic              hit_limit,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [TOL_W-1:0]  cfg_data
);

	localparam logic REG_GUESS_MODE = 1'b0;
	localparam logic REG_TOLERANCE  = 1'b1;

	logic             guess_mode_q;
	logic [TOL_W-1:0] tolerance_q;
	logic             out_valid_q;
	nsr_res_t         res_q;
	nsr_res_t         core_res;
	nsr_stat_t        stat;
	logic [G0_W-1:0]  g0;
	logic             start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guess_mode_q <= 1'b1;
			tolerance_q  <= TOL_W'(42949673);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GUESS_MODE: guess_mode_q <= cfg_data[0];
				REG_TOLERANCE:  tolerance_q  <= cfg_data;
				default:        guess_mode_q <= guess_mode_q;
			endcase
		end
	end

	assign in_ready = stat.idle;
	assign start    = in_valid && stat.idle;

	nsr_start u_start (
		.radicand   (radicand),
		.guess_mode (guess_mode_q),
		.g0         (g0)
	);

	nsr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.radicand  (radicand),
		.g0        (g0),
		.tolerance (tolerance_q),
		.out_free  (!out_valid_q),
		.stat      (stat),
		.res       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) res_q <= core_res;
	end

	assign out_valid  = out_valid_q;
	assign root       = res_q.root;
	assign iterations = res_q.iterations;
	assign hit_limit  = res_q.hit_limit;

endmodule

/* rtl/nsr_checker.sv */
// Port-level checker for the Newton square root block, bound to the top level.
// Depends on nsr_pkg.
module nsr_port_checks import nsr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [ROOT_W-1:0] root,
	input logic [STEP_W-1:0] iterations,
	input logic              hit_limit
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(root) && $stable(iterations))
		else $error("Result beat changed while stalled.");

	a_limit_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_limit |-> iterations == STEP_W'(MAX_STEPS))
		else $error("Limit flag set without the full step count.");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Input taken while a beat is in progress.");

	a_no_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("Result appeared one cycle after its input.");

endmodule

bind newton_square_root nsr_port_checks u_nsr_port_checks (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.root       (root),
	.iterations (iterations),
	.hit_limit  (hit_limit)
);

/* tb/sv/nsr_checker.sv */
`timescale 1ns / 100ps
// Checker for the Newton square root block: watches the input, output and register ports,
// predicts each result from its own copy of the registers and compares field by field.
// Depends on nsr_pkg for widths and the result type.
module nsr_checker import nsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [N_W-1:0]    radicand,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [ROOT_W-1:0] root,
	input  logic [STEP_W-1:0] iterations,
	input  logic              hit_limit,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [TOL_W-1:0]  cfg_data,
	output int                mismatches,
	output int                pending,
	output int                roots_seen,
	output int                limit_hits
);

	localparam logic CFG_MODE = 1'b0;
	localparam logic CFG_TOL  = 1'b1;

	logic             mode_q;
	logic [TOL_W-1:0] tol_q;
	nsr_res_t         expected_roots[$];

	function automatic nsr_res_t root_predict(logic [N_W-1:0] n, logic mode,
			logic [TOL_W-1:0] tol);
		logic [127:0] tgt, tl, g, q, sq, diff;
		logic [N_W-1:0] t;
		logic [63:0] g0;
		int pairs;
		int steps;
		bit ok;
		nsr_res_t r;
		tgt = 128'(n) << 64;
		tl = 128'(tol) << FRAC_BITS;
		g0 = 64'd1;
		if (!mode && n != 0) begin
			t = n;
			pairs = 0;
			while (t >= 100) begin
				t = N_W'(t / 100);
				pairs++;
			end
			g0 = (t < 10) ? 64'd2 : 64'd6;
			repeat (pairs) g0 = g0 * 10;
		end
		g = 128'(g0) << FRAC_BITS;
		steps = 0;
		r.hit_limit = 1'b0;
		while (1) begin
			ok = 0;
			if (g < (128'd1 << (16 + FRAC_BITS))) begin
				sq = g * g;
				diff = (sq >= tgt) ? sq - tgt : tgt - sq;
				ok = diff < tl;
			end
			if (ok) break;
			if (steps >= MAX_STEPS) begin
				r.hit_limit = 1'b1;
				break;
			end
			q = (g == 0) ? 128'd0 : tgt / g;
			g = (g + q) >> 1;
			steps++;
		end
		r.root = g[ROOT_W-1:0];
		r.iterations = STEP_W'(steps);
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	initial begin
		mismatches = 0;
		roots_seen = 0;
		limit_hits = 0;
	end

	assign pending = expected_roots.size();

	always @(posedge clk or negedge arst_n) begin
		nsr_res_t e;
		if (!arst_n) begin
			mode_q <= 1'b1;
			tol_q <= TOL_W'(42949673);
			expected_roots.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MODE) mode_q <= cfg_data[0];
				else tol_q <= cfg_data;
			end
			if (in_valid && in_ready)
				expected_roots.push_back(root_predict(radicand, mode_q, tol_q));
			if (out_valid && out_ready) begin
				roots_seen++;
				if (hit_limit) limit_hits++;
				if (expected_roots.size() == 0) begin
					report("unexpected beat", 64'(root), 64'd0);
				end else begin
					e = expected_roots.pop_front();
					if (root !== e.root) report("root", 64'(root), 64'(e.root));
					if (iterations !== e.iterations)
						report("iterations", 64'(iterations), 64'(e.iterations));
					if (hit_limit !== e.hit_limit)
						report("hit_limit", 64'(hit_limit), 64'(e.hit_limit));
				end
			end
		end
	end

endmodule

/* tb/sv/tb_newton_square_root.sv */
`timescale 1ns / 100ps
// Testbench top for the Newton square root block: clock, reset, register phases, bursty
// stimulus and a stalling receiver; the verdict comes from nsr_checker.
// Depends on nsr_pkg, newton_square_root and nsr_checker.
module tb_newton_square_root;
	import nsr_pkg::*;

	localparam logic CFG_MODE = 1'b0;
	localparam logic CFG_TOL  = 1'b1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [N_W-1:0]    radicand = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [ROOT_W-1:0] root;
	logic [STEP_W-1:0] iterations;
	logic              hit_limit;
	logic              cfg_we = 1'b0;
	logic              cfg_index = CFG_MODE;
	logic [TOL_W-1:0]  cfg_data = '0;
	int                mismatches, pending, roots_seen, limit_hits;
	int                burst_left = 1;
	int                items_sent = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	newton_square_root dut (.*);

	nsr_checker u_checker (.*);

	initial begin
		#200ms;
		$display("Mismatches found");
		$finish;
	end

	// Receiver: random stall pattern, plus one long hold-off that lets the block fill up.
	initial begin
		int level;
		bit held;
		held = 0;
		level = 3;
		forever begin
			@(posedge clk);
			if (!held && roots_seen >= 60) begin
				held = 1;
				out_ready <= 1'b0;
				repeat (40000) @(posedge clk);
			end
			if ($urandom_range(0, 99) == 0) level = $urandom_range(0, 4);
			out_ready <= (level == 4) ? 1'b1 : ($urandom_range(0, 3) < level);
		end
	end

	task automatic send_radicand(logic [N_W-1:0] n);
		radicand <= n;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 40)) @(posedge clk);
			burst_left = $urandom_range(1, 8);
		end
	endtask

	task automatic wait_drained();
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [TOL_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [N_W-1:0] random_radicand();
		logic [N_W-1:0] p;
		int k;
		case ($urandom_range(0, 3))
			0: return N_W'($urandom_range(0, 200));
			1: begin
				k = $urandom_range(0, 4);
				p = 1;
				repeat (k) p = N_W'(p * 100);
				if ($urandom_range(0, 1)) p = N_W'(p * 10);
				return N_W'(p + $urandom_range(0, 2) - 1);
			end
			default: return N_W'($urandom);
		endcase
	endfunction

	task automatic random_phase(int count);
		repeat (count) send_radicand(random_radicand());
	endtask

	initial begin
		logic [N_W-1:0] directed[$];
		directed = '{0, 1, 2, 3, 4, 9, 10, 99, 100, 101, 999, 1000, 9999, 10000,
			100000, 1000000, 99999999, 100000000, 999999999, 1000000000,
			31'h5555_5555, 31'h2AAA_AAAA, 31'h7FFF_FFFF};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed[i]) send_radicand(directed[i]);
		wait_drained();
		write_reg(CFG_MODE, 32'd0);
		foreach (directed[i]) send_radicand(directed[i]);
		random_phase(110);
		wait_drained();

		write_reg(CFG_TOL, 32'd1);
		random_phase(25);
		wait_drained();

		write_reg(CFG_TOL, 32'hFFFF_FFFF);
		random_phase(70);
		wait_drained();

		write_reg(CFG_MODE, 32'd1);
		write_reg(CFG_TOL, 32'd1);
		random_phase(10);
		wait_drained();

		write_reg(CFG_TOL, $urandom_range(1000, 32'h7FFF_FFFF));
		random_phase(80);
		wait_drained();

		write_reg(CFG_MODE, 32'd0);
		write_reg(CFG_TOL, 32'd42949673);
		random_phase(80);
		wait_drained();
		repeat (200) @(posedge clk);

		$display("Sent %0d radicands over six register settings, both start modes.", items_sent);
		$display("Received %0d roots, %0d of them stopped by the step limit.",
			roots_seen, limit_hits);
		if (mismatches == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* newton_square_root.f */
rtl/nsr_pkg.sv
rtl/nsr_start.sv
rtl/nsr_core.sv
rtl/newton_square_root.sv
rtl/nsr_checker.sv
tb/sv/nsr_checker.sv
tb/sv/tb_newton_square_root.sv
